// File: src/iopc_pkg.sv
// iopc_pkg: shared types, event and latency codes, and decode helpers
// for the I/O performance counter unit; no dependencies
package iopc_pkg;

    // default sizes for the top-level parameters
    localparam int NUM_UNITS_DEF     = 64;
    localparam int COUNT_WIDTH_DEF   = 40;
    localparam int LATENCY_WIDTH_DEF = 32;

    // fixed table sizes
    localparam int NUM_EVENTS = 10;
    localparam int NUM_MEANS  = 12;

    // fixed field widths of the words on the ports
    localparam int EV_W       = 4;
    localparam int UNIT_ID_W  = 6;
    localparam int CLS_W      = 2;
    localparam int STG_W      = 2;
    localparam int LAT_IN_W   = 32;
    localparam int CNT_OUT_W  = 40;
    localparam int MEAN_OUT_W = 32;

    // operation codes
    localparam logic OP_COUNT   = 1'b0;
    localparam logic OP_LATENCY = 1'b1;

    // event codes
    localparam logic [EV_W-1:0] EV_READ       = 4'd0;
    localparam logic [EV_W-1:0] EV_WRITE      = 4'd1;
    localparam logic [EV_W-1:0] EV_RMW_READ   = 4'd2;
    localparam logic [EV_W-1:0] EV_RMW_WRITE  = 4'd3;
    localparam logic [EV_W-1:0] EV_GC_READ    = 4'd4;
    localparam logic [EV_W-1:0] EV_GC_WRITE   = 4'd5;
    localparam logic [EV_W-1:0] EV_ERASE      = 4'd6;
    localparam logic [EV_W-1:0] EV_META_READ  = 4'd7;
    localparam logic [EV_W-1:0] EV_META_WRITE = 4'd8;
    localparam logic [EV_W-1:0] EV_GC_RUN     = 4'd9;

    // latency classes
    localparam logic [CLS_W-1:0] CLS_READ  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_WRITE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_RMW   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_GC    = 2'd3;

    // latency stages
    localparam logic [STG_W-1:0] STG_SW    = 2'd0;
    localparam logic [STG_W-1:0] STG_QUEUE = 2'd1;
    localparam logic [STG_W-1:0] STG_TOTAL = 2'd2;

    // input word
    typedef struct packed {
        logic                  op;
        logic [EV_W-1:0]       event_type;
        logic [UNIT_ID_W-1:0]  unit_id;
        logic [CLS_W-1:0]      latency_class;
        logic [STG_W-1:0]      latency_stage;
        logic [LAT_IN_W-1:0]   latency_us;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [CNT_OUT_W-1:0]  event_count;
        logic [CNT_OUT_W-1:0]  unit_count;
        logic [MEAN_OUT_W-1:0] mean_latency_us;
        logic                  saturated;
    } t_out_word;

    // divider status toward the controller
    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_sts;

    // which per-unit counter an event bumps
    typedef enum logic [1:0] {
        US_NONE,
        US_READ,
        US_WRITE
    } t_unit_sel;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COUNT,
        S_PREP,
        S_DIV,
        S_MEAN,
        S_EMIT
    } t_state;

    // per-unit counter touched by an event
    function automatic t_unit_sel unit_sel(input logic [EV_W-1:0] ev);
        t_unit_sel sel;
        unique case (ev) inside
            EV_READ, EV_RMW_READ, EV_GC_READ, EV_META_READ:     sel = US_READ;
            EV_WRITE, EV_RMW_WRITE, EV_GC_WRITE, EV_META_WRITE: sel = US_WRITE;
            EV_ERASE, EV_GC_RUN:                                sel = US_NONE;
            default:                                            sel = US_NONE;
        endcase
        return sel;
    endfunction

    // event counter that holds the sample count of a latency class
    function automatic logic [EV_W-1:0] class_counter(input logic [CLS_W-1:0] cls);
        logic [EV_W-1:0] ev;
        unique case (cls)
            CLS_READ:  ev = EV_READ;
            CLS_WRITE: ev = EV_WRITE;
            CLS_RMW:   ev = EV_RMW_READ;
            CLS_GC:    ev = EV_GC_RUN;
            default:   ev = EV_READ;
        endcase
        return ev;
    endfunction

    // stage code names a mean
    function automatic logic stage_valid(input logic [STG_W-1:0] stg);
        logic ok;
        unique case (stg) inside
            STG_SW, STG_QUEUE, STG_TOTAL: ok = 1'b1;
            default:                      ok = 1'b0;
        endcase
        return ok;
    endfunction

    // mean slot is class * 3 + stage
    function automatic logic [3:0] mean_index(input logic [CLS_W-1:0] cls,
                                              input logic [STG_W-1:0] stg);
        return ({1'b0, cls, 1'b0} + {2'b00, cls}) + {2'b00, stg};
    endfunction

endpackage

// File: src/iopc_ram.sv
// iopc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module iopc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/iopc_div.sv
// iopc_div: radix-2 restoring divider, one quotient bit per cycle
// depends on iopc_pkg for the status struct
module iopc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 41
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic [NUM_W-1:0]    o_quot,
    output iopc_pkg::t_div_sts  o_sts
);
    import iopc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             qbit;
    logic [DEN_W-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        qbit    = !diff[DEN_W];
        n_rem   = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // numerator shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_quot       = r_num;
    assign o_sts.done   = r_done;
    assign o_sts.rem_nz = (r_rem != '0);

endmodule

// File: src/io_perf_counter_unit.sv
// io_perf_counter_unit: event counters, per-unit read/write counters and
// running latency means; uses iopc_pkg, iopc_ram and iopc_div
//
// One word at a time. After reset the per-unit counter RAMs are zeroed in a
// pass over all NUM_UNITS entries with the input stalled. A count word goes
// through RAM read, update and result register (states READ, COUNT, EMIT)
// and the input reopens as its result shows. A latency word goes through
// states PREP, DIV and MEAN before EMIT; the radix-2 divider produces one
// quotient bit per cycle for the mean update floor((mean*n + sample)/(n+1)).
// A word with an unknown event or stage code goes straight to EMIT and
// returns zeros. A finished result sits in the output register, so the next
// word is taken while it waits; a word that finishes while that register is
// still held waits for it to be taken.
module io_perf_counter_unit #(
    parameter int NUM_UNITS     = iopc_pkg::NUM_UNITS_DEF,
    parameter int COUNT_WIDTH   = iopc_pkg::COUNT_WIDTH_DEF,
    parameter int LATENCY_WIDTH = iopc_pkg::LATENCY_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iopc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iopc_pkg::t_out_word o_out_word
);
    import iopc_pkg::*;

    localparam int UW  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int NW  = (LATENCY_WIDTH > LAT_IN_W) ? LATENCY_WIDTH : LAT_IN_W;
    localparam int DW  = COUNT_WIDTH + 1;
    localparam int EIW = $clog2(NUM_EVENTS);
    localparam int MIW = $clog2(NUM_MEANS);
    localparam logic [NW:0] LAT_MAX = {{(NW + 1 - LATENCY_WIDTH){1'b0}},
                                       {LATENCY_WIDTH{1'b1}}};

    t_state                   r_state;
    t_state                   n_state;
    t_in_word                 r_item;
    logic [UW-1:0]            r_clr_idx;
    logic [COUNT_WIDTH-1:0]   r_evc [NUM_EVENTS];
    logic [LATENCY_WIDTH-1:0] r_mean [NUM_MEANS];
    logic [LATENCY_WIDTH-1:0] r_m;
    logic [COUNT_WIDTH-1:0]   r_n;
    logic                     r_ge;
    t_out_word                r_res;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic                     in_acc;
    logic                     out_free;
    logic                     out_take;
    logic                     clr_we;
    logic                     rd_re;
    logic                     cnt_upd;
    logic                     div_start;
    logic                     mean_upd;
    logic                     emit;

    logic [EIW-1:0]           ev_idx;
    logic [COUNT_WIDTH-1:0]   ev_cur;
    logic [COUNT_WIDTH-1:0]   ev_new;
    logic                     ev_sat;
    t_unit_sel                usel;
    logic                     unit_ok;
    logic                     touch;
    logic [UW-1:0]            unit_idx;
    logic [COUNT_WIDTH-1:0]   rd_rdata;
    logic [COUNT_WIDTH-1:0]   wr_rdata;
    logic [COUNT_WIDTH-1:0]   u_cur;
    logic [COUNT_WIDTH-1:0]   u_new;
    logic                     u_sat;
    logic                     rd_we;
    logic                     wr_we;
    logic [UW-1:0]            ram_waddr;
    logic [COUNT_WIDTH-1:0]   ram_wdata;

    logic [MIW-1:0]           mean_idx;
    logic [COUNT_WIDTH-1:0]   n_cur;
    logic [LATENCY_WIDTH-1:0] m_cur;
    logic [NW-1:0]            m_ext;
    logic [NW-1:0]            d_ext;
    logic                     ge;
    logic [NW-1:0]            abs_diff;
    logic [DW-1:0]            den;
    logic [NW-1:0]            quot;
    t_div_sts                 div_sts;
    logic [NW:0]              sum;
    logic [NW:0]              clamped;
    logic [LATENCY_WIDTH-1:0] mean_new;

    // handshakes
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        clr_we     = 1'b0;
        rd_re      = 1'b0;
        cnt_upd    = 1'b0;
        div_start  = 1'b0;
        mean_upd   = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr_idx == UW'(NUM_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_word.op == OP_COUNT) begin
                        n_state = (i_in_word.event_type < EV_W'(NUM_EVENTS)) ? S_READ : S_EMIT;
                    end else begin
                        n_state = stage_valid(i_in_word.latency_stage) ? S_PREP : S_EMIT;
                    end
                end
            end
            S_READ: begin
                rd_re   = 1'b1;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                cnt_upd = 1'b1;
                n_state = S_EMIT;
            end
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                mean_upd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // count path: saturating event and per-unit increments
    always_comb begin
        ev_idx   = EIW'(r_item.event_type);
        ev_cur   = r_evc[ev_idx];
        ev_new   = (ev_cur != '1) ? ev_cur + 1'b1 : ev_cur;
        ev_sat   = (ev_new == '1);
        usel     = unit_sel(r_item.event_type);
        unit_ok  = int'(r_item.unit_id) < NUM_UNITS;
        touch    = (usel != US_NONE) && unit_ok;
        unit_idx = UW'(r_item.unit_id);
        u_cur    = (usel == US_READ) ? rd_rdata : wr_rdata;
        u_new    = (u_cur != '1) ? u_cur + 1'b1 : u_cur;
        u_sat    = (u_new == '1);
    end

    // per-unit RAM writes, zeroed by the clearing pass
    always_comb begin
        rd_we     = clr_we || (cnt_upd && touch && (usel == US_READ));
        wr_we     = clr_we || (cnt_upd && touch && (usel == US_WRITE));
        ram_waddr = clr_we ? r_clr_idx : unit_idx;
        ram_wdata = clr_we ? '0 : u_new;
    end

    iopc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_UNITS)
    ) u_rd_ram (
        .i_clk   (i_clk),
        .i_we    (rd_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_re),
        .i_raddr (unit_idx),
        .o_rdata (rd_rdata)
    );

    iopc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_UNITS)
    ) u_wr_ram (
        .i_clk   (i_clk),
        .i_we    (wr_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_re),
        .i_raddr (unit_idx),
        .o_rdata (wr_rdata)
    );

    // latency path: operands for mean + (sample - mean)/(n + 1)
    always_comb begin
        mean_idx = MIW'(mean_index(r_item.latency_class, r_item.latency_stage));
        n_cur    = r_evc[EIW'(class_counter(r_item.latency_class))];
        m_cur    = r_mean[mean_idx];
        m_ext    = NW'(m_cur);
        d_ext    = NW'(r_item.latency_us);
        ge       = (d_ext >= m_ext);
        abs_diff = ge ? d_ext - m_ext : m_ext - d_ext;
        den      = {1'b0, n_cur} + DW'(1);
    end

    iopc_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (abs_diff),
        .i_den   (den),
        .o_quot  (quot),
        .o_sts   (div_sts)
    );

    // new mean: floor going up, ceiling of the step going down, then clamp
    always_comb begin
        if (r_ge) begin
            sum = {1'b0, NW'(r_m)} + {1'b0, quot};
        end else begin
            sum = {1'b0, NW'(r_m)} - {1'b0, quot} - (NW + 1)'(div_sts.rem_nz);
        end
        clamped  = (sum > LAT_MAX) ? LAT_MAX : sum;
        mean_new = LATENCY_WIDTH'(clamped);
    end

    // counters, means, clearing index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                r_evc[i] <= '0;
            end
            for (int i = 0; i < NUM_MEANS; i++) begin
                r_mean[i] <= '0;
            end
        end else begin
            if (clr_we) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (cnt_upd) begin
                r_evc[ev_idx] <= ev_new;
            end
            if (mean_upd) begin
                r_mean[mean_idx] <= mean_new;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word, operand and result registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_word;
            r_res  <= '0;
        end
        if (div_start) begin
            r_n  <= n_cur;
            r_m  <= m_cur;
            r_ge <= ge;
        end
        if (cnt_upd) begin
            r_res.event_count <= CNT_OUT_W'(ev_new);
            r_res.unit_count  <= touch ? CNT_OUT_W'(u_new) : '0;
            r_res.saturated   <= ev_sat || (touch && u_sat);
        end
        if (mean_upd) begin
            r_res.event_count     <= CNT_OUT_W'(r_n);
            r_res.mean_latency_us <= MEAN_OUT_W'(mean_new);
            r_res.saturated       <= (r_n == '1);
        end
        if (emit) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: src/iopc_checker.sv
// iopc_checker: port-level checks on the I/O performance counter unit,
// bound to the top level; uses iopc_pkg for the result word type
module iopc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input iopc_pkg::t_out_word o_out_word
);
    import iopc_pkg::*;

    // reset starts the clearing pass with nothing to deliver
    assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
    else $error("input not stalled or result pending after reset");

    // one word at a time: an accepted word closes the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
    else $error("input taken again right after an accept");

    // a stalled result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
    else $error("result dropped while stalled");

    // a stalled result word holds its value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
    else $error("result word changed while stalled");

endmodule

bind io_perf_counter_unit iopc_checker u_iopc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
